@@ rtl/crle_pkg.sv @@
// ----------------------------------------------------------------------------
// crle_pkg: shared types and constants of the Catmull-Rom loop evaluator
// Holds the item codes, the payload structs and the weight fraction width.
// ----------------------------------------------------------------------------
package crle_pkg;

   // Table size and field widths, fixed by the item formats.
   localparam int MAX_POINTS  = 8;
   localparam int COORD_WIDTH = 16;
   localparam int PARAM_WIDTH = 16;

   // Operation codes of an input item.
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_EVAL  = 1'b1;

   // Register indexes of the configuration port.
   localparam int REG_POINTS  = 0;
   localparam int REG_TANGENT = 1;

   // Fractional bits of the local parameter and weights; output and segment widths.
   localparam int WFRAC   = 16;
   localparam int OUT_W   = 20;
   localparam int SEG_W   = 3;

   // Payload of a request transfer.
   typedef struct packed {
      logic                          operation;
      logic [2:0]                    point_index;
      logic [1:0]                    axis;
      logic signed [COORD_WIDTH-1:0] coord_value;
      logic [PARAM_WIDTH-1:0]        loop_param;
   } req_item_type;

   // Payload of a response transfer.
   typedef struct packed {
      logic signed [OUT_W-1:0] out_x;
      logic signed [OUT_W-1:0] out_y;
      logic signed [OUT_W-1:0] out_z;
      logic [SEG_W-1:0]        segment;
   } rsp_item_type;

endpackage

@@ rtl/crle_chan_if.sv @@
// ----------------------------------------------------------------------------
// crle_chan_if: valid/ready channel with a generic payload
// Used for the request and the response channels of the evaluator.
// ----------------------------------------------------------------------------
interface crle_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/crle_front.sv @@
// ----------------------------------------------------------------------------
// crle_front: request intake and classification
// Gates coordinate writes into the point table, turns an evaluate request into a
// segment number, a local fraction and four wrapped point indexes, and pushes
// it into a short queue towards the arithmetic back end.
// ----------------------------------------------------------------------------
module crle_front #(
   parameter int MAX_POINTS  = 8,
   parameter int PARAM_WIDTH = 16,
   parameter int PIDX_W      = 3
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_operation,
   input  logic [PIDX_W-1:0]        req_point_index,
   input  logic [1:0]               req_axis,
   input  logic [3:0]               points_in_use,
   output logic                     wr_en,
   output logic [PIDX_W-1:0]        wr_point,
   output logic [1:0]               wr_axis,
   input  logic [PARAM_WIDTH-1:0]   req_loop_param,
   output logic                     job_valid,
   input  logic                     job_ready,
   output logic [4*PIDX_W-1:0]      job_idx,
   output logic [crle_pkg::WFRAC-1:0] job_t,
   output logic [crle_pkg::SEG_W-1:0] job_seg
);
   import crle_pkg::*;

   localparam int JOB_W = 4*PIDX_W + WFRAC + SEG_W;
   localparam int PROD_W = PARAM_WIDTH + 4;

   logic [PROD_W-1:0]      prod;
   logic [3:0]             seg;
   logic [PARAM_WIDTH-1:0] frac;
   logic [WFRAC-1:0]       tf;
   logic [PIDX_W-1:0]      idx [4];
   logic [4:0]             raw;
   logic [JOB_W-1:0]       job_in;
   logic                   push;
   logic                   wr_room;

   // Two-entry queue.
   logic [JOB_W-1:0] q_ff [2];
   logic [JOB_W-1:0] q_in [2];
   logic [1:0]       cnt_ff, cnt_in;

   // Segment and local fraction: the segment fits in four bits as n <= 8.
   always_comb begin
      prod = PROD_W'(req_loop_param) * PROD_W'(points_in_use);
      seg  = prod[PROD_W-1 -: 4];
      frac = prod[PARAM_WIDTH-1:0];
      if (PARAM_WIDTH >= WFRAC) begin
         tf = WFRAC'(frac >> (PARAM_WIDTH >= WFRAC ? PARAM_WIDTH - WFRAC : 0));
      end else begin
         tf = WFRAC'(frac) << (PARAM_WIDTH >= WFRAC ? 0 : WFRAC - PARAM_WIDTH);
      end
      // Wrapped neighbours; the sum stays below 2n+2, so two subtracts wrap each.
      for (int i = 0; i < 4; i++) begin
         raw = 5'(seg) + 5'(i) + 5'(points_in_use) - 5'd1;
         if (raw >= 5'(points_in_use)) raw = raw - 5'(points_in_use);
         if (raw >= 5'(points_in_use)) raw = raw - 5'(points_in_use);
         idx[i] = PIDX_W'(raw);
      end
      job_in = {idx[0], idx[1], idx[2], idx[3], tf, seg[SEG_W-1:0]};
   end

   // Evaluations wait for queue room. A write waits until every queued
   // evaluation has read the table, so none sees a later coordinate.
   assign wr_room   = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && job_ready);
   assign req_ready = (req_operation == OP_WRITE) ? wr_room : (cnt_ff != 2'd2);
   assign push      = req_valid && req_ready && (req_operation == OP_EVAL);
   assign wr_en     = req_valid && req_ready && (req_operation == OP_WRITE)
                      && (req_axis != 2'd3) && (32'(req_point_index) < MAX_POINTS);
   assign wr_point  = req_point_index;
   assign wr_axis   = req_axis;

   // Queue update.
   always_comb begin
      logic pop;
      logic [1:0] c;
      pop  = job_valid && job_ready;
      q_in = q_ff;
      c    = cnt_ff;
      if (pop) begin
         q_in[0] = q_ff[1];
         c = c - 2'd1;
      end
      if (push) begin
         q_in[c[0]] = job_in;
         c = c + 2'd1;
      end
      cnt_in = c;
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign job_valid = (cnt_ff != 2'd0);
   assign {job_idx, job_t, job_seg} = q_ff[0];
endmodule

@@ rtl/crle_back.sv @@
// ----------------------------------------------------------------------------
// crle_back: basis weights and blending pipeline
// Reads the four points, forms t^2 and t^3, the four basis weights and the
// weighted sums, then rounds and saturates into an output register.
// ----------------------------------------------------------------------------
module crle_back #(
   parameter int MAX_POINTS  = 8,
   parameter int COORD_WIDTH = 16,
   parameter int PIDX_W      = 3
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       tangent_mode,
   input  logic                       wr_en,
   input  logic [PIDX_W-1:0]          wr_point,
   input  logic [1:0]                 wr_axis,
   input  logic [COORD_WIDTH-1:0]     wr_data,
   input  logic                       job_valid,
   output logic                       job_ready,
   input  logic [4*PIDX_W-1:0]        job_idx,
   input  logic [crle_pkg::WFRAC-1:0] job_t,
   input  logic [crle_pkg::SEG_W-1:0] job_seg,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [crle_pkg::OUT_W-1:0] rsp_x,
   output logic [crle_pkg::OUT_W-1:0] rsp_y,
   output logic [crle_pkg::OUT_W-1:0] rsp_z,
   output logic [crle_pkg::SEG_W-1:0] rsp_seg
);
   import crle_pkg::*;

   localparam int WW  = WFRAC + 5;           // signed weight width
   localparam int PW  = WW + COORD_WIDTH;    // product width
   localparam int AW  = PW + 2;              // sum of four

   // Point table per axis, one read port per neighbour.
   logic [COORD_WIDTH-1:0] mem_x [MAX_POINTS];
   logic [COORD_WIDTH-1:0] mem_y [MAX_POINTS];
   logic [COORD_WIDTH-1:0] mem_z [MAX_POINTS];

   logic advance;
   // Stage 1: points read, t registered.
   logic                   s1_v_ff;
   logic [COORD_WIDTH-1:0] s1_p_ff [3][4];
   logic [WFRAC-1:0]       s1_t_ff;
   logic [SEG_W-1:0]       s1_seg_ff;
   // Stage 2: t^2.
   logic                   s2_v_ff;
   logic [COORD_WIDTH-1:0] s2_p_ff [3][4];
   logic [WFRAC-1:0]       s2_t_ff, s2_t2_ff;
   logic [SEG_W-1:0]       s2_seg_ff;
   // Stage 3: t^3.
   logic                   s3_v_ff;
   logic [COORD_WIDTH-1:0] s3_p_ff [3][4];
   logic [WFRAC-1:0]       s3_t_ff, s3_t2_ff, s3_t3_ff;
   logic [SEG_W-1:0]       s3_seg_ff;
   // Stage 4: weights.
   logic                   s4_v_ff;
   logic [COORD_WIDTH-1:0] s4_p_ff [3][4];
   logic signed [WW-1:0]   s4_w_ff [4];
   logic [SEG_W-1:0]       s4_seg_ff;
   // Stage 5: products.
   logic                   s5_v_ff;
   logic signed [PW-1:0]   s5_m_ff [3][4];
   logic [SEG_W-1:0]       s5_seg_ff;
   // Output register.
   logic                   o_v_ff;
   logic [OUT_W-1:0]       o_ff [3];
   logic [SEG_W-1:0]       o_seg_ff;

   logic signed [WW-1:0]   w_in [4];
   logic [OUT_W-1:0]       res [3];

   // The pipeline moves as a whole while the output register can be refilled.
   assign advance   = !o_v_ff || rsp_ready;
   assign job_ready = advance;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         case (wr_axis)
            2'd0:    mem_x[wr_point] <= wr_data;
            2'd1:    mem_y[wr_point] <= wr_data;
            default: mem_z[wr_point] <= wr_data;
         endcase
      end
   end

   // Weights, doubled, 16 fractional bits.
   always_comb begin
      logic signed [WW-1:0] t, t2, t3, one;
      t   = WW'(s3_t_ff);
      t2  = WW'(s3_t2_ff);
      t3  = WW'(s3_t3_ff);
      one = WW'(1) <<< WFRAC;
      if (tangent_mode) begin
         w_in[0] = -(WW'(3) * t2) + WW'(4) * t - one;
         w_in[1] =  WW'(9) * t2 - WW'(10) * t;
         w_in[2] = -(WW'(9) * t2) + WW'(8) * t + one;
         w_in[3] =  WW'(3) * t2 - WW'(2) * t;
      end else begin
         w_in[0] = -t3 + WW'(2) * t2 - t;
         w_in[1] =  WW'(3) * t3 - WW'(5) * t2 + WW'(2) * one;
         w_in[2] = -(WW'(3) * t3) + WW'(4) * t2 + t;
         w_in[3] =  t3 - t2;
      end
   end

   // Sum, round half up, saturate.
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         logic signed [AW-1:0] acc, q;
         acc = AW'(s5_m_ff[a][0]) + AW'(s5_m_ff[a][1]) + AW'(s5_m_ff[a][2])
             + AW'(s5_m_ff[a][3]) + (AW'(1) <<< WFRAC);
         q = acc >>> (WFRAC + 1);
         if (q > AW'((1 <<< (OUT_W-1)) - 1))   res[a] = {1'b0, {(OUT_W-1){1'b1}}};
         else if (q < -(AW'(1) <<< (OUT_W-1))) res[a] = {1'b1, {(OUT_W-1){1'b0}}};
         else                                   res[a] = q[OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 4; i++) begin
            s1_p_ff[0][i] <= mem_x[job_idx[(3-i)*PIDX_W +: PIDX_W]];
            s1_p_ff[1][i] <= mem_y[job_idx[(3-i)*PIDX_W +: PIDX_W]];
            s1_p_ff[2][i] <= mem_z[job_idx[(3-i)*PIDX_W +: PIDX_W]];
         end
         s1_t_ff   <= job_t;
         s1_seg_ff <= job_seg;
         s2_p_ff   <= s1_p_ff;
         s2_t_ff   <= s1_t_ff;
         s2_t2_ff  <= WFRAC'(((2*WFRAC)'(s1_t_ff) * (2*WFRAC)'(s1_t_ff)) >> WFRAC);
         s2_seg_ff <= s1_seg_ff;
         s3_p_ff   <= s2_p_ff;
         s3_t_ff   <= s2_t_ff;
         s3_t2_ff  <= s2_t2_ff;
         s3_t3_ff  <= WFRAC'(((2*WFRAC)'(s2_t2_ff) * (2*WFRAC)'(s2_t_ff)) >> WFRAC);
         s3_seg_ff <= s2_seg_ff;
         s4_p_ff   <= s3_p_ff;
         s4_w_ff   <= w_in;
         s4_seg_ff <= s3_seg_ff;
         for (int a = 0; a < 3; a++) begin
            for (int i = 0; i < 4; i++) begin
               s5_m_ff[a][i] <= PW'(s4_w_ff[i]) * PW'($signed(s4_p_ff[a][i]));
            end
         end
         s5_seg_ff <= s4_seg_ff;
         o_ff      <= res;
         o_seg_ff  <= s5_seg_ff;
      end
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
         s5_v_ff <= 1'b0;
         o_v_ff  <= 1'b0;
      end else if (advance) begin
         s1_v_ff <= job_valid;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
         s4_v_ff <= s3_v_ff;
         s5_v_ff <= s4_v_ff;
         o_v_ff  <= s5_v_ff;
      end
   end

   assign rsp_valid = o_v_ff;
   assign rsp_x     = o_ff[0];
   assign rsp_y     = o_ff[1];
   assign rsp_z     = o_ff[2];
   assign rsp_seg   = o_seg_ff;
endmodule

@@ rtl/catmull_rom_loop_evaluator.sv @@
// ----------------------------------------------------------------------------
// catmull_rom_loop_evaluator: closed-loop Catmull-Rom curve evaluator
// Channel  Dir  Handshake      Payload
// req      in   valid/ready    operation, point_index, axis, coord_value,
//                              loop_param
// rsp      out  valid/ready    out_x, out_y, out_z, segment
// csr      in   APB write/read points_in_use (0x0), tangent_mode (0x4)
//
// One request is taken each cycle while the front queue has room and no write
// waits. An evaluation passes the front queue, then five pipeline stages (table
// read, t^2, t^3, weights, products) and the rounding into the output register.
// Reset is synchronous; the point table is not cleared. The whole back
// pipeline halts while a result waits; the queue then fills and holds ready low.
// A write waits while a queued evaluation has not yet read the table.
// ----------------------------------------------------------------------------
module catmull_rom_loop_evaluator (
   input  logic        clock,
   input  logic        reset,
   crle_chan_if.sink   req,
   crle_chan_if.source rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import crle_pkg::*;

   localparam int PIDX_W = $clog2(MAX_POINTS);

   logic [3:0] points_ff, points_in;
   logic       tangent_ff, tangent_in;
   logic [3:0] wv;

   logic              wr_en;
   logic [PIDX_W-1:0] wr_point;
   logic [1:0]        wr_axis;
   logic              job_valid, job_ready;
   logic [4*PIDX_W-1:0] job_idx;
   logic [WFRAC-1:0]  job_t;
   logic [SEG_W-1:0]  job_seg;

   // Register file: the point count is clamped into its legal range.
   assign csr_pready = 1'b1;
   always_comb begin
      points_in  = points_ff;
      tangent_in = tangent_ff;
      wv         = csr_pwdata[3:0];
      if (csr_psel && csr_penable && csr_pwrite) begin
         if (csr_paddr[2] == 1'(REG_TANGENT)) begin
            tangent_in = csr_pwdata[0];
         end else if (32'(wv) < 4) begin
            points_in = 4'd4;
         end else if (32'(wv) > MAX_POINTS) begin
            points_in = 4'(MAX_POINTS);
         end else begin
            points_in = wv;
         end
      end
      csr_prdata = (csr_paddr[2] == 1'(REG_TANGENT)) ? {31'd0, tangent_ff}
                                                     : {28'd0, points_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         points_ff  <= 4'd5;
         tangent_ff <= 1'b0;
      end else begin
         points_ff  <= points_in;
         tangent_ff <= tangent_in;
      end
   end

   crle_front #(
      .MAX_POINTS(MAX_POINTS), .PARAM_WIDTH(PARAM_WIDTH), .PIDX_W(PIDX_W)
   ) u_front (
      .clock, .reset,
      .req_valid(req.valid), .req_ready(req.ready),
      .req_operation(req.data.operation),
      .req_point_index(PIDX_W'(req.data.point_index)),
      .req_axis(req.data.axis),
      .points_in_use(points_ff),
      .wr_en, .wr_point, .wr_axis,
      .req_loop_param(req.data.loop_param),
      .job_valid, .job_ready, .job_idx, .job_t, .job_seg
   );

   crle_back #(
      .MAX_POINTS(MAX_POINTS), .COORD_WIDTH(COORD_WIDTH), .PIDX_W(PIDX_W)
   ) u_back (
      .clock, .reset,
      .tangent_mode(tangent_ff),
      .wr_en, .wr_point, .wr_axis, .wr_data(req.data.coord_value),
      .job_valid, .job_ready, .job_idx, .job_t, .job_seg,
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .rsp_x(rsp.data.out_x), .rsp_y(rsp.data.out_y), .rsp_z(rsp.data.out_z),
      .rsp_seg(rsp.data.segment)
   );
endmodule

@@ rtl/crle_checker.sv @@
// ----------------------------------------------------------------------------
// crle_checker: port-level checks of the evaluator
// Watches the response handshake and the configuration port over time.
// ----------------------------------------------------------------------------
module crle_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_segment,
   input logic        csr_pready,
   input logic        req_valid,
   input logic        req_ready
);
   // A stalled result holds its segment.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_segment))
      else $error("response dropped while stalled");

   // No result leaves in the cycle after reset.
   a_reset: assert property (@(posedge clock) $past(reset) && !reset |-> !rsp_valid)
      else $error("result after reset");

   // The register port never waits.
   a_pready: assert property (@(posedge clock) csr_pready)
      else $error("pready low");

   // Requests are taken while the output has stayed empty.
   a_flow: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && $past(!rsp_valid) && $past(!rsp_valid, 2) |-> req_ready)
      else $error("request blocked with an empty output");
endmodule

bind catmull_rom_loop_evaluator crle_checker u_checker (
   .clock, .reset,
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_segment(rsp.data.segment),
   .csr_pready, .req_valid(req.valid), .req_ready(req.ready)
);
